// File: rtl/gso_pkg.sv
// Package: shared constants, types and saturating arithmetic for the orthogonaliser.
package gso_pkg;

  localparam int MAX_DIM     = 8;
  localparam int MAX_VECTORS = 8;

  localparam int DIM_W  = $clog2(MAX_DIM);
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int VEC_W  = $clog2(MAX_VECTORS);
  localparam int ADDR_W = VEC_W + DIM_W;
  localparam int BASIS_DEPTH = MAX_VECTORS * (2 ** DIM_W);

  localparam int DATA_W  = 32;
  localparam int ACC_W   = 64;
  localparam int CIDX_W  = 8;
  localparam int CDATA_W = 32;
  localparam int VIDX_W  = 3;
  localparam int REG_W   = 4;

  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // Long division of |dot| * 2^16 by the norm: one quotient bit a cycle
  localparam int DIV_STEPS = ACC_W + 16;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [CIDX_W-1:0] REG_DIMENSION    = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_VECTOR_COUNT = CIDX_W'(1);

  typedef logic [MAX_DIM-1:0][DATA_W-1:0] row_t;

  typedef struct packed {
    logic [CNT_W-1:0] dim;
    logic [CNT_W-1:0] count;
    logic             clear;
  } gso_cfg_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DOT_RD,
    BK_DOT_MUL,
    BK_DOT_ACC,
    BK_DIV_START,
    BK_DIV,
    BK_FAC,
    BK_PRJ_RD,
    BK_PRJ_MUL,
    BK_PRJ_ACC,
    BK_OUT
  } bk_state_t;

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
      s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    return s;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_sub(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a - b;
    if (a[ACC_W-1] != b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
      s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    return s;
  endfunction

  // Arithmetic shift by 16 (floor), then clamp to 32 bits
  function automatic logic [DATA_W-1:0] floor_sat32(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-17:0] sh;
    logic [DATA_W-1:0] r;
    sh = x[ACC_W-1:16];
    if (sh > $signed({{(ACC_W-16-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}}))
      r = {1'b0, {(DATA_W-1){1'b1}}};
    else if (sh < $signed({{(ACC_W-16-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}}))
      r = {1'b1, {(DATA_W-1){1'b0}}};
    else
      r = sh[DATA_W-1:0];
    return r;
  endfunction

endpackage

// File: rtl/gso_if.sv
// Interfaces: input element, result and configuration write channels.
interface gso_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] element;
  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface gso_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] ortho_value;
  logic [2:0]  vector_index;
  logic        last_element;
  logic        zero_norm;
  modport source (output valid, output ortho_value, output vector_index,
                  output last_element, output zero_norm, input ready);
  modport sink   (input valid, input ortho_value, input vector_index,
                  input last_element, input zero_norm, output ready);
endinterface

interface gso_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/gso_front.sv
// Front end: gathers input elements into a row and queues each complete vector.
module gso_front (
  input  logic              clk,
  input  logic              rst_n,
  input  gso_pkg::gso_cfg_t cfg,
  gso_in_if.sink            in_ch,
  input  logic              full,
  output logic              push,
  output gso_pkg::row_t     push_row
);
  import gso_pkg::*;

  logic [DIM_W-1:0] ecnt_r, ecnt_nxt;
  row_t             row_r;
  logic             accept;
  logic             complete;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign complete    = (CNT_W'(ecnt_r) + CNT_W'(1)) == cfg.dim;
  assign push        = accept && complete;

  always_comb begin
    push_row         = row_r;
    push_row[ecnt_r] = in_ch.element;
  end

  always_comb begin
    ecnt_nxt = ecnt_r;
    if (cfg.clear) begin
      ecnt_nxt = '0;
    end else if (accept) begin
      ecnt_nxt = complete ? '0 : ecnt_r + DIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecnt_r <= '0;
    end else begin
      ecnt_r <= ecnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_r[ecnt_r] <= in_ch.element;
    end
  end

endmodule

// File: rtl/gso_fifo.sv
// Short vector queue between the front end and the back end.
module gso_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gso_pkg::row_t push_row,
  input  logic          pop,
  output gso_pkg::row_t head_row,
  output logic          full,
  output logic          empty
);
  import gso_pkg::*;

  row_t              slot_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wptr_r, wptr_nxt;
  logic [FPTR_W-1:0] rptr_r, rptr_nxt;
  logic [FCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = cnt_r == FCNT_W'(FIFO_DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_row = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_r + FPTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_r + FPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + FCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - FCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_row;
    end
  end

endmodule

// File: rtl/gso_back.sv
// Back end: projections against the stored basis, serial divider and result output.
module gso_back (
  input  logic              clk,
  input  logic              rst_n,
  input  gso_pkg::gso_cfg_t cfg,
  input  logic              empty,
  input  gso_pkg::row_t     head_row,
  output logic              pop,
  gso_out_if.source         out_ch
);
  import gso_pkg::*;

  bk_state_t st_r, st_nxt;

  logic [DATA_W-1:0] basis_mem [BASIS_DEPTH];
  logic [DATA_W-1:0] rdata_r;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic              mem_we;

  row_t                    row_r;
  logic signed [ACC_W-1:0] psum_r [MAX_DIM];
  logic signed [ACC_W-1:0] dot_r, norm_r;
  logic signed [ACC_W-1:0] prod_a_r, prod_b_r;
  logic signed [DATA_W-1:0] fac_r;
  logic                    zflag_r;
  logic [DIM_W-1:0]        i_r;
  logic [VEC_W-1:0]        l_r, k_r;

  logic [DIV_STEPS-1:0]    div_r;
  logic [ACC_W-1:0]        rem_r;
  logic [DATA_W:0]         q_r;
  logic                    ovf_r, neg_r;
  logic [DCNT_W-1:0]       dcnt_r;

  logic [DATA_W-1:0] oval_r;
  logic [VIDX_W-1:0] oidx_r;
  logic              olast_r, ozero_r, ovalid_r;

  logic                    last_i, last_l, out_go;
  logic [ACC_W:0]          rem_sh, rem_dif;
  logic                    q_bit;
  logic signed [DATA_W-1:0] cur_row;
  logic [DATA_W-1:0]       result;
  logic [ACC_W-1:0]        dot_mag;
  logic [DATA_W-1:0]       fac_mag;
  logic                    q_big;

  assign last_i  = (CNT_W'(i_r) + CNT_W'(1)) == cfg.dim;
  assign last_l  = ((VEC_W+1)'(l_r) + (VEC_W+1)'(1)) == (VEC_W+1)'(k_r);
  assign out_go  = !ovalid_r || out_ch.ready;
  assign cur_row = $signed(row_r[i_r]);
  assign result  = floor_sat32(sat_sub({{(ACC_W-DATA_W-16){cur_row[DATA_W-1]}}, cur_row, 16'b0},
                                       psum_r[i_r]));
  assign dot_mag = dot_r[ACC_W-1] ? ACC_W'(-dot_r) : ACC_W'(dot_r);

  // Restoring division step
  assign rem_sh  = {rem_r, div_r[DIV_STEPS-1]};
  assign rem_dif = rem_sh - {1'b0, norm_r};
  assign q_bit   = !rem_dif[ACC_W];

  // Quotient at or above 2^31 saturates either way
  assign q_big = ovf_r || q_r[DATA_W];
  always_comb begin
    if (neg_r) begin
      fac_mag = (q_big || q_r[DATA_W-1:0] > {1'b1, {(DATA_W-1){1'b0}}})
                ? {1'b1, {(DATA_W-1){1'b0}}} : q_r[DATA_W-1:0];
    end else begin
      fac_mag = (q_big || q_r[DATA_W-1]) ? {1'b0, {(DATA_W-1){1'b1}}} : q_r[DATA_W-1:0];
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE:      if (!empty) st_nxt = (k_r == '0) ? BK_OUT : BK_DOT_RD;
      BK_DOT_RD:    st_nxt = BK_DOT_MUL;
      BK_DOT_MUL:   st_nxt = BK_DOT_ACC;
      BK_DOT_ACC:   st_nxt = last_i ? BK_DIV_START : BK_DOT_RD;
      BK_DIV_START: st_nxt = (norm_r == '0) ? BK_PRJ_RD : BK_DIV;
      BK_DIV:       if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) st_nxt = BK_FAC;
      BK_FAC:       st_nxt = BK_PRJ_RD;
      BK_PRJ_RD:    st_nxt = BK_PRJ_MUL;
      BK_PRJ_MUL:   st_nxt = BK_PRJ_ACC;
      BK_PRJ_ACC: begin
        if (last_i) st_nxt = last_l ? BK_OUT : BK_DOT_RD;
        else        st_nxt = BK_PRJ_RD;
      end
      BK_OUT:       if (out_go && last_i) st_nxt = BK_IDLE;
      default:      st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop    = (st_r == BK_IDLE) && !empty;
    mem_we = (st_r == BK_OUT) && out_go;
    raddr  = {l_r, i_r};
    waddr  = {k_r, i_r};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      basis_mem[waddr] <= result;
    end
    rdata_r <= basis_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= BK_IDLE;
      k_r      <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_go) begin
        ovalid_r <= mem_we;
      end
      if (cfg.clear) begin
        k_r <= '0;
      end else if (mem_we && last_i) begin
        k_r <= ((CNT_W'(k_r) + CNT_W'(1)) >= cfg.count) ? '0 : k_r + VEC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      BK_IDLE: begin
        row_r   <= head_row;
        zflag_r <= 1'b0;
        i_r     <= '0;
        l_r     <= '0;
        dot_r   <= '0;
        norm_r  <= '0;
        for (int j = 0; j < MAX_DIM; j++) psum_r[j] <= '0;
      end
      BK_DOT_MUL: begin
        prod_a_r <= $signed(row_r[i_r]) * $signed(rdata_r);
        prod_b_r <= $signed(rdata_r) * $signed(rdata_r);
      end
      BK_DOT_ACC: begin
        dot_r  <= sat_add(dot_r, prod_a_r);
        norm_r <= sat_add(norm_r, prod_b_r);
        i_r    <= last_i ? '0 : i_r + DIM_W'(1);
      end
      BK_DIV_START: begin
        if (norm_r == '0) begin
          zflag_r <= 1'b1;
          fac_r   <= '0;
        end
        div_r  <= {dot_mag, 16'b0};
        neg_r  <= dot_r[ACC_W-1];
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
        dcnt_r <= '0;
      end
      BK_DIV: begin
        rem_r  <= q_bit ? rem_dif[ACC_W-1:0] : rem_sh[ACC_W-1:0];
        q_r    <= {q_r[DATA_W-1:0], q_bit};
        ovf_r  <= ovf_r | q_r[DATA_W];
        div_r  <= {div_r[DIV_STEPS-2:0], 1'b0};
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
      BK_FAC: begin
        fac_r <= neg_r ? $signed(-fac_mag) : $signed(fac_mag);
      end
      BK_PRJ_MUL: begin
        prod_a_r <= fac_r * $signed(rdata_r);
      end
      BK_PRJ_ACC: begin
        psum_r[i_r] <= sat_add(psum_r[i_r], prod_a_r);
        i_r         <= last_i ? '0 : i_r + DIM_W'(1);
        if (last_i && !last_l) begin
          l_r    <= l_r + VEC_W'(1);
          dot_r  <= '0;
          norm_r <= '0;
        end
      end
      BK_OUT: begin
        if (out_go) begin
          oval_r  <= result;
          oidx_r  <= VIDX_W'(k_r);
          olast_r <= last_i;
          ozero_r <= zflag_r;
          i_r     <= last_i ? '0 : i_r + DIM_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.ortho_value  = oval_r;
  assign out_ch.vector_index = oidx_r;
  assign out_ch.last_element = olast_r;
  assign out_ch.zero_norm    = ozero_r;

endmodule

// File: rtl/gram_schmidt_orthogonaliser_top.sv
// Top level: configuration registers, front end, vector queue and back end.
// Elements (signed Q16.16) are taken one a cycle while the two-vector queue
// has room; a completed vector of d elements is then worked by the back end,
// which pops it and, for the k-th vector of a set, against each earlier basis
// vector forms a dot product and a norm element by element through one
// basis-memory read port, after a setup step runs a bit-serial divider (skipped
// for a zero norm), forms the factor and updates the projections, and then puts
// out each result element in turn while the receiver is ready. Config writes are
// always accepted; writes to the dimension and vector-count registers restart
// the element and vector counters; issue them only with nothing in flight.
module gram_schmidt_orthogonaliser_top (
  input  logic      clk,
  input  logic      rst_n,
  gso_in_if.sink    in_ch,
  gso_out_if.source out_ch,
  gso_cfg_if.sink   cfg_ch
);
  import gso_pkg::*;

  logic [REG_W-1:0] dim_r, count_r;
  logic             cfg_wr;
  gso_cfg_t         cfg;
  logic [CNT_W-1:0] eff_dim, eff_cnt;
  logic             push, pop, full, empty;
  row_t             push_row, head_row;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    if (dim_r == '0)                       eff_dim = CNT_W'(1);
    else if (dim_r > REG_W'(MAX_DIM))      eff_dim = CNT_W'(MAX_DIM);
    else                                   eff_dim = CNT_W'(dim_r);
    if (count_r == '0)                     eff_cnt = CNT_W'(1);
    else if (count_r > REG_W'(MAX_VECTORS)) eff_cnt = CNT_W'(MAX_VECTORS);
    else                                   eff_cnt = CNT_W'(count_r);
    if (eff_cnt > eff_dim) eff_cnt = eff_dim;
  end

  assign cfg.dim   = eff_dim;
  assign cfg.count = eff_cnt;
  assign cfg.clear = cfg_wr && (cfg_ch.index == REG_DIMENSION ||
                                cfg_ch.index == REG_VECTOR_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r   <= REG_W'(MAX_DIM);
      count_r <= REG_W'(MAX_VECTORS);
    end else if (cfg_wr) begin
      if (cfg_ch.index == REG_DIMENSION)    dim_r   <= cfg_ch.data[REG_W-1:0];
      if (cfg_ch.index == REG_VECTOR_COUNT) count_r <= cfg_ch.data[REG_W-1:0];
    end
  end

  gso_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .full     (full),
    .push     (push),
    .push_row (push_row)
  );

  gso_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_row (push_row),
    .pop      (pop),
    .head_row (head_row),
    .full     (full),
    .empty    (empty)
  );

  gso_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .empty    (empty),
    .head_row (head_row),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// File: tb/gso_checker.sv
// Checker: watches the channels, predicts orthogonalised results and compares them.
`timescale 1ns / 1ps
module gso_checker (
  input  logic clk,
  input  logic rst_n,
  gso_in_if    in_ch,
  gso_out_if   out_ch,
  gso_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  import gso_pkg::*;

  typedef struct {
    logic [31:0] value;
    logic [2:0]  vidx;
    logic        last;
    logic        zn;
  } ortho_t;

  ortho_t ortho_q[$];

  logic [3:0]  dim_reg, cnt_reg;
  logic signed [31:0] row_mem [8];
  logic signed [31:0] basis_mem [64];
  logic [2:0]  elem_cnt, vec_cnt;

  assign pending = ortho_q.size();

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic longint acc_add(input longint a, input longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic longint acc_sub(input longint a, input longint b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  // Q16.16 projection factor, truncated toward zero, clamped to 32 bits
  function automatic longint proj_factor(input longint dot, input longint norm);
    logic [63:0] n, mag, qi, rem, q;
    logic neg;
    n = norm;
    neg = dot < 0;
    mag = neg ? 64'd0 - 64'(dot) : 64'(dot);
    qi = mag / n;
    rem = mag % n;
    if (qi > 64'h10000) qi = 64'h10000;
    q = qi << 16;
    for (int b = 15; b >= 0; b--) begin
      rem = rem << 1;
      if (rem >= n) begin
        rem = rem - n;
        q[b] = 1'b1;
      end
    end
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return -longint'(q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return longint'(q);
  endfunction

  function automatic logic [31:0] clamp32(input longint x);
    if (x > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'h8000_0000;
    return x[31:0];
  endfunction

  task automatic take_element(input logic [31:0] e);
    int d, cnt, k;
    longint psum [8];
    longint dot, norm, f, diff;
    logic zflag;
    ortho_t r;
    d = (dim_reg == 0) ? 1 : (dim_reg > MAX_DIM) ? MAX_DIM : int'(dim_reg);
    cnt = (cnt_reg == 0) ? 1 : (cnt_reg > MAX_VECTORS) ? MAX_VECTORS : int'(cnt_reg);
    if (cnt > d) cnt = d;
    zflag = 1'b0;
    row_mem[elem_cnt] = e;
    elem_cnt = elem_cnt + 3'd1;
    if (elem_cnt != 0 && elem_cnt < d) return;
    if (elem_cnt == 0 && d != 8) return;
    k = vec_cnt;
    for (int i = 0; i < 8; i++) psum[i] = 0;
    for (int l = 0; l < k; l++) begin
      dot = 0;
      norm = 0;
      for (int i = 0; i < d; i++) begin
        dot = acc_add(dot, longint'(row_mem[i]) * longint'(basis_mem[l*8+i]));
        norm = acc_add(norm, longint'(basis_mem[l*8+i]) * longint'(basis_mem[l*8+i]));
      end
      if (norm == 0) begin
        f = 0;
        zflag = 1'b1;
      end else begin
        f = proj_factor(dot, norm);
      end
      for (int i = 0; i < d; i++)
        psum[i] = acc_add(psum[i], f * longint'(basis_mem[l*8+i]));
    end
    for (int i = 0; i < d; i++) begin
      diff = acc_sub(longint'(row_mem[i]) * 65536, psum[i]);
      r.value = clamp32(diff >>> 16);
      basis_mem[k*8+i] = r.value;
      r.vidx = k[2:0];
      r.last = (i + 1 == d);
      r.zn = zflag;
      ortho_q.push_back(r);
    end
    elem_cnt = 0;
    vec_cnt = (k + 1 >= cnt) ? 3'd0 : 3'(k + 1);
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    ortho_t x;
    if (!rst_n) begin
      dim_reg = 4'd8;
      cnt_reg = 4'd8;
      elem_cnt = 0;
      vec_cnt = 0;
      for (int i = 0; i < 8; i++) row_mem[i] = 0;
      for (int i = 0; i < 64; i++) basis_mem[i] = 0;
      ortho_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_DIMENSION || cfg_ch.index == REG_VECTOR_COUNT) begin
          if (cfg_ch.index == REG_DIMENSION) dim_reg = cfg_ch.data[3:0];
          else cnt_reg = cfg_ch.data[3:0];
          elem_cnt = 0;
          vec_cnt = 0;
        end
      end
      if (in_ch.valid && in_ch.ready) take_element(in_ch.element);
      if (out_ch.valid && out_ch.ready) begin
        if (ortho_q.size() == 0) begin
          report($sformatf("unexpected result %h", out_ch.ortho_value));
        end else begin
          x = ortho_q.pop_front();
          if (out_ch.ortho_value !== x.value)
            report($sformatf("ortho_value %h, want %h", out_ch.ortho_value, x.value));
          if (out_ch.vector_index !== x.vidx)
            report($sformatf("vector_index %0d, want %0d", out_ch.vector_index, x.vidx));
          if (out_ch.last_element !== x.last)
            report($sformatf("last_element %b, want %b", out_ch.last_element, x.last));
          if (out_ch.zero_norm !== x.zn)
            report($sformatf("zero_norm %b, want %b", out_ch.zero_norm, x.zn));
        end
      end
    end
  end
endmodule

// File: tb/testbench.sv
// Testbench top: clock, reset, stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
  import gso_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_WAIT     = 1200;
  localparam int HOLD_CYCLES    = 3000;

  logic clk, rst_n;
  int   fail_count, pending;
  int   sent;
  bit   quiet, hold_req, hold_done;
  int   idle_cycles;

  gso_in_if  in_ch();
  gso_out_if out_ch();
  gso_cfg_if cfg_ch();

  gram_schmidt_orthogonaliser_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  gso_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.element = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = 0;
    cfg_ch.data = 0;
  end

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end
  initial idle_cycles = 0;

  // Receiver: random stall bursts plus one long hold-off
  initial begin
    int burst, hold;
    burst = 0;
    hold = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 17) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] pick_element();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h0;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
    endcase
  endfunction

  task automatic send_element(input logic [31:0] e);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.element <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [3:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= {28'($urandom()), val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int eff_dim(input logic [3:0] v);
    return (v == 0) ? 1 : (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  initial begin
    logic [3:0] dims [12];
    logic [3:0] cnts [12];
    logic [3:0] dv, cv;
    int d, c, nvec, ph;
    dims = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd2, 4'd4, 4'd5, 4'd8,
             4'd6, 4'd7, 4'd12, 4'd2};
    cnts = '{4'd1, 4'd0, 4'd15, 4'd2, 4'd5, 4'd4, 4'd9, 4'd3,
             4'd1, 4'd7, 4'd0, 4'd8};
    sent = 0;
    quiet = 0;
    hold_req = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: extremes, then a zero vector so the next
    // vector projects onto a zero norm
    send_element(32'h7FFF_FFFF); send_element(32'h8000_0000);
    send_element(32'h0000_0000); send_element(32'hFFFF_FFFF);
    send_element(32'h0001_0000); send_element(32'hFFFF_0000);
    send_element(32'h0000_0001); send_element(32'h5555_AAAA);
    for (int i = 0; i < 8; i++) send_element(32'h0);
    for (int i = 0; i < 8; i++) send_element(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    go_idle();

    ph = 0;
    while (sent < 320) begin
      if (ph < 12) begin
        dv = dims[ph];
        cv = cnts[ph];
      end else begin
        dv = 4'($urandom());
        cv = 4'($urandom());
      end
      ph++;
      write_reg(REG_DIMENSION, dv);
      write_reg(REG_VECTOR_COUNT, cv);
      if (ph == 6) write_reg(8'd2, 4'($urandom()));  // unknown index, ignored
      d = eff_dim(dv);
      c = eff_dim(cv);
      if (c > d) c = d;
      nvec = c + $urandom_range(0, c);
      for (int v = 0; v < nvec; v++) begin
        for (int i = 0; i < d; i++) send_element(pick_element());
        if (sent >= 80) hold_req = 1;
        if (ph == 8 && v == 0) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      if (sent >= 270) quiet = 1;
      // Partial vector, dropped by the next register write
      if (ph % 3 == 1 && d > 1)
        for (int i = 0; i < d - 1; i++) send_element(pick_element());
      go_idle();
    end

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// File: filelist.f
rtl/gso_pkg.sv
rtl/gso_if.sv
rtl/gso_front.sv
rtl/gso_fifo.sv
rtl/gso_back.sv
rtl/gram_schmidt_orthogonaliser_top.sv
tb/gso_checker.sv
tb/testbench.sv
